/* sv/dat_pkg.sv */
// Package for the dictionary article transcoder: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package dat_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_SEQ_COUNT = 3'd0;
  localparam logic [2:0] CFG_SEQ_A     = 3'd1;
  localparam logic [2:0] CFG_SEQ_B     = 3'd2;
  localparam logic [2:0] CFG_SEQ_C     = 3'd3;
  localparam logic [2:0] CFG_SEQ_D     = 3'd4;

  // How the back end expands one classified request
  typedef enum logic [2:0] {
    K_NONE,    // nothing to emit, only a possible status
    K_BYTE,    // one literal byte
    K_AMP,
    K_LT,
    K_GT,
    K_QUOT,
    K_BR
  } kind_t;

  // Request passed from front to back through the queue
  typedef struct packed {
    logic [5:0] nuls;    // held NULs to release first
    kind_t      kind;
    logic [7:0] data;
    logic       stat_en; // a status result follows
    logic       stat;    // malformed flag
  } req_t;

  function automatic logic [2:0] kind_len(input kind_t k);
    logic [2:0] n;
    n = 3'd0;
    unique case (k)
      K_NONE: n = 3'd0;
      K_BYTE: n = 3'd1;
      K_AMP:  n = 3'd5;
      K_LT:   n = 3'd4;
      K_GT:   n = 3'd4;
      K_QUOT: n = 3'd6;
      K_BR:   n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kind_char(input kind_t k, input logic [2:0] i,
                                           input logic [7:0] d);
    logic [7:0] c;
    c = d;
    unique case (k)
      K_AMP: begin
        unique case (i)
          3'd0: c = "&"; 3'd1: c = "a"; 3'd2: c = "m"; 3'd3: c = "p";
          default: c = ";";
        endcase
      end
      K_LT: begin
        unique case (i)
          3'd0: c = "&"; 3'd1: c = "l"; 3'd2: c = "t";
          default: c = ";";
        endcase
      end
      K_GT: begin
        unique case (i)
          3'd0: c = "&"; 3'd1: c = "g"; 3'd2: c = "t";
          default: c = ";";
        endcase
      end
      K_QUOT: begin
        unique case (i)
          3'd0: c = "&"; 3'd1: c = "q"; 3'd2: c = "u"; 3'd3: c = "o";
          3'd4: c = "t"; default: c = ";";
        endcase
      end
      K_BR: begin
        unique case (i)
          3'd0: c = "<"; 3'd1: c = "b"; 3'd2: c = "r"; 3'd3: c = "/";
          default: c = ">";
        endcase
      end
      default: c = d;
    endcase
    return c;
  endfunction

endpackage

/* sv/dictionary_article_transcoder.sv */
// Top level: dictionary article transcoder. Accepts one article byte a cycle unless the queue is full.
// The first result of an accepted byte passes through the queue and the back end's output register.
// Throughput: one input byte per cycle while the queue is not full; results leave one at a time, so an
//   escape (up to 6 bytes) or released NULs hold the input through the 4-deep queue.
// Reset: synchronous active-low rst_n clears article state, queue and registers.
`timescale 1ns / 1ps
module dictionary_article_transcoder
  import dat_pkg::*;
#(
  parameter int SEQ_MAX         = 31,
  parameter int PENDING_NUL_MAX = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte
  input  logic        in_tlast,   // article_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic [1:0]  out_tuser,  // [0] is_status, [1] status
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [4:0]  cnt_r;
  logic [63:0] sa_r, sb_r, sc_r, sd_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; sa_r <= '0; sb_r <= '0; sc_r <= '0; sd_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SEQ_COUNT: cnt_r <= cfg_data[4:0];
        CFG_SEQ_A:     sa_r <= cfg_data;
        CFG_SEQ_B:     sb_r <= cfg_data;
        CFG_SEQ_C:     sc_r <= cfg_data;
        CFG_SEQ_D:     sd_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic full, empty, rd, step;
  req_t wreq, rreq;

  assign in_tready = !full;
  assign step      = in_tvalid && !full;

  dat_front #(.SEQ_MAX(SEQ_MAX), .PENDING_NUL_MAX(PENDING_NUL_MAX)) u_front (
    .clk, .rst_n, .step, .b(in_tdata), .fin(in_tlast),
    .seq_count(cnt_r), .seq_types({sd_r, sc_r, sb_r, sa_r}), .req(wreq)
  );

  dat_queue u_queue (
    .clk, .rst_n, .wr(step), .wdata(wreq), .full, .rd, .rdata(rreq), .empty
  );

  dat_back u_back (
    .clk, .rst_n, .q_empty(empty), .q_data(rreq), .q_rd(rd),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

endmodule

/* sv/dat_front.sv */
// Front end: parses article bytes into field state and classifies each byte.
// Depends on dat_pkg.
`timescale 1ns / 1ps
module dat_front
  import dat_pkg::*;
#(
  parameter int SEQ_MAX         = 31,
  parameter int PENDING_NUL_MAX = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   b,
  input  logic         fin,
  input  logic [4:0]   seq_count,
  input  logic [255:0] seq_types,
  output req_t         req
);

  typedef enum logic [1:0] {PH_START, PH_LENGTH, PH_DATA, PH_FAILED} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  fidx_r, fidx_nxt;
  logic [7:0]  ftype_r, ftype_nxt;
  logic [31:0] len_r, len_nxt;
  logic [1:0]  lseen_r, lseen_nxt;
  logic [5:0]  pend_r, pend_nxt;
  logic        err_r, err_nxt;
  logic        rest_r, rest_nxt;

  logic [4:0] cnt_eff;
  assign cnt_eff = (32'(seq_count) > SEQ_MAX) ? 5'(SEQ_MAX) : seq_count;

  function automatic logic lower(input logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction
  function automatic logic upper(input logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  always_comb begin
    logic [7:0]  t;
    logic        do_data, do_len, rest_f, counted, raw, ok, dend;
    logic [31:0] lv;
    phase_nxt = phase_r; fidx_nxt = fidx_r; ftype_nxt = ftype_r;
    len_nxt = len_r; lseen_nxt = lseen_r; pend_nxt = pend_r;
    err_nxt = err_r; rest_nxt = rest_r;
    req = '0;
    req.kind = K_NONE;
    do_data = 1'b0; do_len = 1'b0; dend = 1'b0;
    t = seq_types[{fidx_r, 3'b000} +: 8];
    lv = '0; rest_f = 1'b0; counted = 1'b0; raw = 1'b0;

    // Field start
    unique case (phase_r)
      PH_START: begin
        if (cnt_eff == 5'd0) begin
          ftype_nxt = b; rest_nxt = 1'b0; len_nxt = '0; lseen_nxt = '0;
          if (lower(b)) phase_nxt = PH_DATA;
          else if (upper(b)) phase_nxt = PH_LENGTH;
          else begin err_nxt = 1'b1; phase_nxt = PH_FAILED; pend_nxt = '0; end
        end else begin
          rest_f = (6'(fidx_r) + 6'd1) >= 6'(cnt_eff);
          ftype_nxt = t; rest_nxt = rest_f; len_nxt = '0; lseen_nxt = '0;
          if (lower(t) || (upper(t) && rest_f)) do_data = 1'b1;
          else if (upper(t)) do_len = 1'b1;
          else begin err_nxt = 1'b1; phase_nxt = PH_FAILED; pend_nxt = '0; end
        end
      end
      PH_LENGTH: do_len = 1'b1;
      PH_DATA:   do_data = 1'b1;
      default: ;
    endcase

    // Length byte
    if (do_len) begin
      phase_nxt = PH_LENGTH;
      lv = {len_nxt[23:0], b};
      len_nxt = lv;
      if (lseen_nxt == 2'd3) begin
        lseen_nxt = '0;
        if (lv == '0) dend = 1'b1;
        else phase_nxt = PH_DATA;
      end else begin
        lseen_nxt = lseen_nxt + 2'd1;
      end
    end

    // Data byte
    if (do_data) begin
      phase_nxt = PH_DATA;
      counted = upper(ftype_nxt) && !rest_nxt;
      raw = ftype_nxt == "h" || ftype_nxt == "g" || ftype_nxt == "x";
      if (lower(ftype_nxt) && !rest_nxt && b == 8'd0) begin
        dend = 1'b1;
      end else begin
        if (b == 8'd0) begin
          if (32'(pend_nxt) < PENDING_NUL_MAX) pend_nxt = pend_nxt + 6'd1;
        end else begin
          req.nuls = pend_nxt;
          pend_nxt = '0;
          req.data = b;
          if (raw) req.kind = K_BYTE;
          else begin
            unique case (b)
              "&":   req.kind = K_AMP;
              "<":   req.kind = K_LT;
              ">":   req.kind = K_GT;
              8'h22: req.kind = K_QUOT;
              8'h0a: req.kind = K_BR;
              8'h0d: req.kind = K_NONE;
              default: req.kind = K_BYTE;
            endcase
          end
        end
        if (counted) begin
          if (len_nxt != '0) len_nxt = len_nxt - 32'd1;
          if (len_nxt == '0) dend = 1'b1;
        end
      end
    end

    // Field end
    if (dend) begin
      pend_nxt = '0; len_nxt = '0; lseen_nxt = '0; rest_nxt = 1'b0;
      if (cnt_eff != 5'd0 && fidx_r < 5'd31) fidx_nxt = fidx_r + 5'd1;
      phase_nxt = PH_START;
    end

    // Article end
    if (fin) begin
      ok = !err_nxt && (phase_nxt == PH_START || (phase_nxt == PH_DATA && rest_nxt));
      req.stat_en = 1'b1;
      req.stat = !ok;
      phase_nxt = PH_START; fidx_nxt = '0; ftype_nxt = '0; len_nxt = '0;
      lseen_nxt = '0; pend_nxt = '0; err_nxt = 1'b0; rest_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START; fidx_r <= '0; ftype_r <= '0; len_r <= '0;
      lseen_r <= '0; pend_r <= '0; err_r <= 1'b0; rest_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt; fidx_r <= fidx_nxt; ftype_r <= ftype_nxt;
      len_r <= len_nxt; lseen_r <= lseen_nxt; pend_r <= pend_nxt;
      err_r <= err_nxt; rest_r <= rest_nxt;
    end
  end

endmodule

/* sv/dat_queue.sv */
// Short request queue between front and back end.
// Depends on dat_pkg.
`timescale 1ns / 1ps
module dat_queue
  import dat_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  req_t wdata,
  output logic full,
  input  logic rd,
  output req_t rdata,
  output logic empty
);

  req_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full  = cnt_r == 3'd4;
  assign empty = cnt_r == 3'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
  end

endmodule

/* sv/dat_back.sv */
// Back end: expands requests into NULs, literal bytes, entity or <br/> text and status results.
// Depends on dat_pkg.
`timescale 1ns / 1ps
module dat_back
  import dat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  req_t       q_data,
  output logic       q_rd,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [1:0] out_tuser,
  output logic       out_tlast
);

  typedef enum logic [1:0] {S_NUL, S_TXT, S_STAT} step_t;

  logic [5:0] ncnt_r;
  logic [2:0] ci_r;
  step_t      st_r;
  logic       v_r, last_r, iss_r, stv_r;
  logic [7:0] d_r;

  logic [2:0] tlen;
  req_t       cur;
  assign cur  = q_data;
  assign tlen = kind_len(cur.kind);

  // Skip parts of the head request that have nothing left to emit
  step_t es;
  always_comb begin
    if (st_r == S_NUL && ncnt_r != cur.nuls) es = S_NUL;
    else if (st_r != S_STAT && ci_r != tlen) es = S_TXT;
    else es = S_STAT;
  end

  // Next result from the head request
  logic       have, is_s;
  logic [7:0] ob;
  always_comb begin
    have = 1'b1; is_s = 1'b0; ob = '0;
    unique case (es)
      S_NUL:  ob = '0;
      S_TXT:  ob = kind_char(cur.kind, ci_r, cur.data);
      S_STAT: begin
        is_s = cur.stat_en;
        have = cur.stat_en;
      end
      default: have = 1'b0;
    endcase
  end

  // Does anything follow this result within the request
  logic more;
  always_comb begin
    unique case (es)
      S_NUL:  more = (ncnt_r + 6'd1 != cur.nuls) || tlen != 3'd0 || cur.stat_en;
      S_TXT:  more = (ci_r + 3'd1 != tlen) || cur.stat_en;
      default: more = 1'b0;
    endcase
  end

  logic adv;
  assign adv  = !q_empty && (!v_r || out_tready);
  assign q_rd = adv && (!have || !more);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_NUL; ncnt_r <= '0; ci_r <= '0; v_r <= 1'b0;
    end else begin
      if (adv && have) v_r <= 1'b1;
      else if (out_tready) v_r <= 1'b0;
      if (adv && have) begin
        d_r <= ob; iss_r <= is_s; stv_r <= is_s & cur.stat;
        last_r <= !more;
      end
      if (adv) begin
        if (q_rd) begin
          st_r <= S_NUL; ncnt_r <= '0; ci_r <= '0;
        end else begin
          st_r <= es;
          unique case (es)
            S_NUL:   ncnt_r <= ncnt_r + 6'd1;
            S_TXT:   ci_r <= ci_r + 3'd1;
            default: ;
          endcase
        end
      end
    end
  end

  assign out_tvalid = v_r;
  assign out_tdata  = iss_r ? 8'd0 : d_r;
  assign out_tuser  = {stv_r, iss_r};
  assign out_tlast  = last_r;

endmodule

/* dv/tb_dictionary_article_transcoder.sv */
// Testbench for the dictionary article transcoder: a scoreboard class with a
// bit-true predictor of the article parser and HTML escaper. Depends on dat_pkg.
`timescale 1ns / 1ps
module tb_dictionary_article_transcoder;
  import dat_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       is_stat;
    logic       stat;
    logic       tl;
  } html_res_t;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_FAILED = 2'd3;
  localparam int NUL_CAP = 32;

  // Scoreboard: article parser model plus queue of expected HTML results
  class html_scoreboard;
    html_res_t  pending_html[$];
    logic [4:0]  seq_cnt;
    logic [63:0] seq_w[4];
    logic [1:0]  phase;
    logic [4:0]  fidx;
    logic [7:0]  ftype;
    logic [31:0] len_left;
    logic [1:0]  len_seen;
    logic [5:0]  nuls;
    bit          err, rest;
    int          errors, results, statuses;
    html_res_t   step_out[$];

    function void clear_article();
      phase = PH_START; fidx = 0; ftype = 0; len_left = 0; len_seen = 0;
      nuls = 0; err = 0; rest = 0;
    endfunction

    function void reset_all();
      seq_cnt = 0;
      foreach (seq_w[i]) seq_w[i] = 0;
      clear_article();
      pending_html.delete();
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        CFG_SEQ_COUNT: seq_cnt = v[4:0];
        CFG_SEQ_A: seq_w[0] = v;
        CFG_SEQ_B: seq_w[1] = v;
        CFG_SEQ_C: seq_w[2] = v;
        CFG_SEQ_D: seq_w[3] = v;
        default: ;
      endcase
    endfunction

    function void put(logic [7:0] b, bit s, bit st);
      step_out.push_back('{b, s, st, 1'b0});
    endfunction

    function void put_str(string s);
      for (int i = 0; i < s.len(); i++) put(s[i], 0, 0);
    endfunction

    function bit lower(logic [7:0] c); return c >= "a" && c <= "z"; endfunction
    function bit upper(logic [7:0] c); return c >= "A" && c <= "Z"; endfunction

    function void fail_art(); err = 1; phase = PH_FAILED; nuls = 0; endfunction

    function void end_field();
      nuls = 0; len_left = 0; len_seen = 0; rest = 0;
      if (seq_cnt != 0 && fidx < 31) fidx++;
      phase = PH_START;
    endfunction

    function void emit_text(logic [7:0] b);
      bit raw;
      raw = ftype == "h" || ftype == "g" || ftype == "x";
      while (nuls > 0) begin put(0, 0, 0); nuls--; end
      if (raw) put(b, 0, 0);
      else case (b)
        "&": put_str("&amp;");
        "<": put_str("&lt;");
        ">": put_str("&gt;");
        "\"": put_str("&quot;");
        8'h0a: put_str("<br/>");
        8'h0d: ;
        default: put(b, 0, 0);
      endcase
    endfunction

    function void data_byte(logic [7:0] b);
      bit counted;
      counted = upper(ftype) && !rest;
      phase = PH_DATA;
      if (lower(ftype) && !rest && b == 0) begin end_field(); return; end
      if (b == 0) begin if (nuls < NUL_CAP) nuls++; end
      else emit_text(b);
      if (counted) begin
        if (len_left > 0) len_left--;
        if (len_left == 0) end_field();
      end
    endfunction

    function void length_byte(logic [7:0] b);
      phase = PH_LENGTH;
      len_left = {len_left[23:0], b};
      if (len_seen >= 3) begin
        len_seen = 0;
        if (len_left == 0) end_field(); else phase = PH_DATA;
      end else len_seen++;
    endfunction

    function void field_start(logic [7:0] b);
      logic [7:0] t;
      if (seq_cnt == 0) begin
        ftype = b; rest = 0; len_left = 0; len_seen = 0;
        if (lower(b)) phase = PH_DATA;
        else if (upper(b)) phase = PH_LENGTH;
        else fail_art();
        return;
      end
      t = seq_w[fidx[4:3]][fidx[2:0]*8 +: 8];
      ftype = t;
      rest = (32'(fidx) + 1) >= 32'(seq_cnt);
      len_left = 0; len_seen = 0;
      if (lower(t)) data_byte(b);
      else if (upper(t)) begin
        if (rest) data_byte(b); else length_byte(b);
      end else fail_art();
    endfunction

    // Note an accepted article byte and queue what it produces
    function void note_byte(logic [7:0] b, bit last_byte);
      bit ok;
      step_out.delete();
      case (phase)
        PH_START:  field_start(b);
        PH_LENGTH: length_byte(b);
        PH_DATA:   data_byte(b);
        default: ;
      endcase
      if (last_byte) begin
        ok = !err && (phase == PH_START || (phase == PH_DATA && rest));
        put(0, 1, !ok);
        clear_article();
      end
      if (step_out.size() > 0) step_out[$].tl = 1;
      foreach (step_out[i]) pending_html.push_back(step_out[i]);
    endfunction

    function void check_result(html_res_t got);
      html_res_t exp;
      results++;
      if (pending_html.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending_html.pop_front();
      if (exp.is_stat) statuses++;
      if (exp !== got) begin
        $display("%0t: mismatch expected byte=%h st=%b stat=%b last=%b, got byte=%h st=%b stat=%b last=%b",
                 $time, exp.data, exp.is_stat, exp.stat, exp.tl,
                 got.data, got.is_stat, got.stat, got.tl);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  dictionary_article_transcoder u_top (.*);

  html_scoreboard sb;
  int send_idle, recv_idle;
  int unsigned cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result('{out_tdata, out_tuser[0], out_tuser[1], out_tlast});
    if (!rst_n) out_tready <= 0;
    else out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Valid stays high between back-to-back requests; drain() drops it
  task automatic send_byte(logic [7:0] b, bit e);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= b; in_tlast <= e;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, e);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending_html.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [63:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_len(logic [31:0] n);
    for (int i = 3; i >= 0; i--) send_byte(n[i*8 +: 8], 0);
  endtask

  function automatic logic [7:0] rand_text();
    case ($urandom_range(9))
      0: return 0;
      1: return "&";
      2: return "<";
      3: return ">";
      4: return "\"";
      5: return 8'h0a;
      6: return 8'h0d;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] rand_type();
    logic [7:0] t[8] = '{"h", "g", "x", "m", "H", "K", "t", "Z"};
    if ($urandom_range(19) == 0) return 8'($urandom_range(255));
    return t[$urandom_range(7)];
  endfunction

  // One random article; self-describing or sequenced per current registers
  task automatic rand_article(int budget);
    int nf, n, used;
    logic [7:0] t;
    used = 0;
    nf = $urandom_range(1, 3);
    for (int f = 0; f < nf && used < budget; f++) begin
      if (sb.seq_cnt == 0) begin
        t = rand_type(); send_byte(t, 0); used++;
      end else t = sb.seq_w[f[4:3]][f[2:0]*8 +: 8];
      n = $urandom_range(0, 6);
      if (sb.seq_cnt != 0 && f + 1 >= sb.seq_cnt) begin
        for (int i = 0; i < n; i++) send_byte(rand_text(), 0);
        used += n; break;
      end
      if (t >= "A" && t <= "Z") begin
        send_len($urandom_range(9) == 0 ? n + 2 : n); used += 4;
      end
      for (int i = 0; i < n; i++) begin
        logic [7:0] c;
        c = rand_text();
        if (t >= "a" && t <= "z" && c == 0) c = "q";
        send_byte(c, 0);
      end
      used += n;
      if (t >= "a" && t <= "z" && $urandom_range(9) != 0) send_byte(0, 0);
    end
    send_byte($urandom_range(9) == 0 ? 8'h00 : rand_text(), 1);
  endtask

  initial begin
    sb = new();
    sb.reset_all();
    cycles = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tlast = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    send_idle = 0; recv_idle = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: escapes, raw types, NUL runs, zero length, malformed cases
    send_byte("m", 0);
    send_byte("&", 0); send_byte("<", 0); send_byte(">", 0);
    send_byte("\"", 0); send_byte("a", 0); send_byte("b", 0);
    send_byte(8'h0a, 0); send_byte(8'h0d, 0); send_byte(0, 0);
    send_byte("h", 0); send_byte("<", 0); send_byte(0, 0);
    send_byte("H", 0); send_len(40); for (int i = 0; i < 38; i++) send_byte(0, 0);
    send_byte("&", 0); send_byte(0, 1);
    send_byte("X", 0); send_len(0); send_byte(8'hff, 1);
    send_byte(8'h80, 0); send_byte("a", 1);
    send_byte("G", 0); send_byte(1, 1);
    send_byte("t", 0); send_byte("z", 1);
    drain();

    // Sequence registers at several settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle = 6; recv_idle = 75; end
        1: begin send_idle = 75; recv_idle = 6; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      write_cfg(CFG_SEQ_A, ph == 1 ? 64'h0 : {$urandom(), $urandom()} & 64'h0 |
                {"h", "x", "G", "m", "g", "K", "t", "H"});
      write_cfg(CFG_SEQ_B, {8{8'("a" + ph)}});
      write_cfg(CFG_SEQ_C, ph == 5 ? 64'hffff_ffff_ffff_ffff : {8{"Q"}});
      write_cfg(CFG_SEQ_D, {8{"x"}});
      write_cfg(CFG_SEQ_COUNT,
                64'(ph == 0 ? 0 : ph == 2 ? 31 : ph == 3 ? 1 : $urandom_range(2, 9)));
      for (int a = 0; a < 4; a++) rand_article(30);
      drain();
    end
    write_cfg(CFG_SEQ_COUNT, 64'd0);
    for (int a = 0; a < 4; a++) rand_article(30);
    drain();

    $display("Covered escapes, raw and counted fields, NUL hold, malformed articles;");
    $display("%0d results checked, %0d status results.", sb.results, sb.statuses);
    if (sb.errors == 0 && sb.pending_html.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

/* files.f */
sv/dat_pkg.sv
sv/dat_front.sv
sv/dat_queue.sv
sv/dat_back.sv
sv/dictionary_article_transcoder.sv
dv/tb_dictionary_article_transcoder.sv
